@@ src/ecb_pkg.sv @@
// Shared types, widths and fixed-point helpers of the camera basis block.
// Depends on nothing; every other file of the block imports it.
package ecb_pkg;

	localparam int ANGLE_BITS  = 16;
	localparam int FRAC_BITS   = 15;
	localparam int QBITS       = ANGLE_BITS - 2;
	localparam int POLY_Q      = 30;
	localparam int POLY_W      = POLY_Q + 1;
	localparam int T_SHIFT     = POLY_Q - QBITS;
	localparam int SW          = FRAC_BITS + 2;
	localparam int OW          = FRAC_BITS + 3;
	localparam int IN_W        = 3 * ANGLE_BITS;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 9 * OW;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int SINE_STAGES = 9;

	localparam logic [POLY_W-1:0] K1  = POLY_W'(1686629713);
	localparam logic [POLY_W-1:0] K3  = POLY_W'(693598668);
	localparam logic [POLY_W-1:0] K5  = POLY_W'(85569306);
	localparam logic [POLY_W-1:0] K7  = POLY_W'(5026995);
	localparam logic [POLY_W-1:0] K9  = POLY_W'(172271);
	localparam logic [POLY_W-1:0] K11 = POLY_W'(3864);

	localparam logic signed [SW-1:0] ONE_FX   = SW'(2 ** FRAC_BITS);
	localparam logic signed [OW-1:0] LIMIT_FX = OW'(2 ** (FRAC_BITS + 1));

	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [SW-1:0] fx_t;
	typedef logic signed [OW-1:0] out_t;

	typedef struct packed {
		angle_t roll;
		angle_t yaw;
		angle_t pitch;
	} angles_t;

	typedef struct packed {
		fx_t sp;
		fx_t cp;
		fx_t sy;
		fx_t cy;
		fx_t sr;
		fx_t cr;
	} trig_t;

	typedef struct packed {
		out_t fwd_z;
		out_t fwd_y;
		out_t fwd_x;
		out_t up_z;
		out_t up_y;
		out_t up_x;
		out_t right_z;
		out_t right_y;
		out_t right_x;
	} basis_t;

	// product rounded to FRAC_BITS, half away from zero
	function automatic fx_t fx_mul(fx_t a, fx_t b);
		logic signed [2*SW-1:0] p;
		logic [2*SW-1:0] m;
		logic [2*SW-1:0] r;
		p = a * b;
		m = p[2*SW-1] ? (2*SW)'(-p) : (2*SW)'(p);
		r = (m + ((2*SW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return p[2*SW-1] ? -signed'(r[SW-1:0]) : signed'(r[SW-1:0]);
	endfunction

	function automatic out_t ext(fx_t v);
		return OW'(v);
	endfunction

	function automatic out_t sat(out_t v);
		if (v > LIMIT_FX) begin
			return LIMIT_FX;
		end else if (v < -LIMIT_FX) begin
			return -LIMIT_FX;
		end
		return v;
	endfunction

endpackage

@@ src/euler_to_camera_basis.sv @@
// Camera basis from pitch, yaw and roll binary angles (65536 per turn). Each
// transfer in gives one transfer out: right row negated, up row, forward row
// doubled, nine signed Q2.15 values. One angle triple is taken every cycle while
// the output is not held off; the path runs through the polynomial sine pipelines
// (at most one 31x31 multiply per stage) and the product and sum stages behind them.
// Depends on ecb_pkg, ecb_trig and ecb_basis.
module euler_to_camera_basis
	import ecb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pitch_angle, yaw_angle, roll_angle
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // right_x, right_y, right_z, up_x, up_y,
	                                              // up_z, fwd_x, fwd_y, fwd_z, zero fill
);

	angles_t angles;
	trig_t   trig;
	logic    trig_valid;
	logic    trig_ready;
	basis_t  basis;

	assign angles = angles_t'(s_axis_tdata[IN_W-1:0]);

	ecb_trig u_trig (
		.clk,
		.arst_n,
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_angles (angles),
		.out_valid (trig_valid),
		.out_ready (trig_ready),
		.out_trig  (trig)
	);

	ecb_basis u_basis (
		.clk,
		.arst_n,
		.in_valid  (trig_valid),
		.in_ready  (trig_ready),
		.in_trig   (trig),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_basis (basis)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[OUT_W-1:0] = basis;
	end

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input held off while output side is free");

	a_fwd_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !basis.fwd_x[0] && !basis.fwd_y[0] && !basis.fwd_z[0])
		else $error("doubled forward row has odd value");

	a_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> basis.right_x <= LIMIT_FX && basis.right_x >= -LIMIT_FX)
		else $error("right_x outside saturation range");

	a_up_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> basis.up_z <= OW'(ONE_FX) && basis.up_z >= -OW'(ONE_FX))
		else $error("up_z exceeds unit magnitude");

endmodule

@@ src/ecb_sine.sv @@
// Pipelined sine of one binary angle: quarter-wave fold, odd polynomial by
// Horner steps, at most one multiplier per stage. Depends on ecb_pkg.
module ecb_sine
	import ecb_pkg::*;
(
	input  logic                   clk,
	input  logic [SINE_STAGES-1:0] en,
	input  logic                   is_cos,
	input  angle_t                 angle,
	output fx_t                    sine
);

	function automatic logic [POLY_W-1:0] mul_hi(logic [POLY_W-1:0] a, logic [POLY_W-1:0] b);
		logic [2*POLY_W-1:0] p;
		p = a * b;
		return p[POLY_Q +: POLY_W];
	endfunction

	localparam logic [QBITS:0] QUARTER = {1'b1, {QBITS{1'b0}}};
	localparam logic [31:0] ROUND_HALF = 32'(1) << (POLY_Q - 1 - FRAC_BITS);
	localparam logic [31:0] ONE_W = 32'(1) << FRAC_BITS;

	angle_t a_rot;
	logic [1:0] quad;
	logic [QBITS:0] frac;
	logic [POLY_W-1:0] t_in;
	logic [31:0] rsum;
	logic [31:0] rq;
	logic [SW-1:0] mag;

	logic [QBITS:0] u_s1;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [POLY_W-1:0] t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [POLY_W-1:0] t2_s2, t2_s3, t2_s4, t2_s5, t2_s6;
	logic [POLY_W-1:0] p_s3, p_s4, p_s5, p_s6, p_s7;
	logic [POLY_W-1:0] r_s8;
	fx_t sine_s9;

	always_comb begin
		a_rot = is_cos ? angle + ANGLE_BITS'(QUARTER) : angle;
		quad  = a_rot[ANGLE_BITS-1 -: 2];
		frac  = {1'b0, a_rot[QBITS-1:0]};
		t_in  = {u_s1, {T_SHIFT{1'b0}}};
		rsum  = {1'b0, r_s8} + ROUND_HALF;
		rq    = rsum >> (POLY_Q - FRAC_BITS);
		mag   = (rq > ONE_W) ? SW'(ONE_W) : rq[SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s1   <= quad[0] ? QUARTER - frac : frac;
			neg_s1 <= quad[1];
		end
		if (en[1]) begin
			t_s2   <= t_in;
			t2_s2  <= mul_hi(t_in, t_in);
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			p_s3   <= K9 - mul_hi(K11, t2_s2);
			t_s3   <= t_s2;
			t2_s3  <= t2_s2;
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			p_s4   <= K7 - mul_hi(p_s3, t2_s3);
			t_s4   <= t_s3;
			t2_s4  <= t2_s3;
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			p_s5   <= K5 - mul_hi(p_s4, t2_s4);
			t_s5   <= t_s4;
			t2_s5  <= t2_s4;
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			p_s6   <= K3 - mul_hi(p_s5, t2_s5);
			t_s6   <= t_s5;
			t2_s6  <= t2_s5;
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			p_s7   <= K1 - mul_hi(p_s6, t2_s6);
			t_s7   <= t_s6;
			neg_s7 <= neg_s6;
		end
		if (en[7]) begin
			r_s8   <= mul_hi(p_s7, t_s7);
			neg_s8 <= neg_s7;
		end
		if (en[8]) begin
			sine_s9 <= neg_s8 ? -signed'(mag) : signed'(mag);
		end
	end

	assign sine = sine_s9;

endmodule

@@ src/ecb_trig.sv @@
// Sine and cosine of pitch, yaw and roll: six sine pipelines in lockstep
// and the valid chain that steps them. Depends on ecb_pkg and ecb_sine.
module ecb_trig
	import ecb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  angles_t in_angles,
	output logic    out_valid,
	input  logic    out_ready,
	output trig_t   out_trig
);

	logic [SINE_STAGES-1:0] valid_q;
	logic [SINE_STAGES-1:0] en;

	always_comb begin
		en[SINE_STAGES-1] = !valid_q[SINE_STAGES-1] || out_ready;
		for (int k = SINE_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < SINE_STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[SINE_STAGES-1];

	ecb_sine u_sp (.clk, .en, .is_cos(1'b0), .angle(in_angles.pitch), .sine(out_trig.sp));
	ecb_sine u_cp (.clk, .en, .is_cos(1'b1), .angle(in_angles.pitch), .sine(out_trig.cp));
	ecb_sine u_sy (.clk, .en, .is_cos(1'b0), .angle(in_angles.yaw),   .sine(out_trig.sy));
	ecb_sine u_cy (.clk, .en, .is_cos(1'b1), .angle(in_angles.yaw),   .sine(out_trig.cy));
	ecb_sine u_sr (.clk, .en, .is_cos(1'b0), .angle(in_angles.roll),  .sine(out_trig.sr));
	ecb_sine u_cr (.clk, .en, .is_cos(1'b1), .angle(in_angles.roll),  .sine(out_trig.cr));

endmodule

@@ src/ecb_basis.sv @@
// Rotation products and saturating sums that form the camera basis rows.
// Three stages: pair products, triple products, sums. Depends on ecb_pkg.
module ecb_basis
	import ecb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  trig_t  in_trig,
	output logic   out_valid,
	input  logic   out_ready,
	output basis_t out_basis
);

	localparam int NST = 3;

	logic [NST-1:0] valid_q;
	logic [NST-1:0] en;

	fx_t srsp_s1, crsp_s1, crsy_s1, crcy_s1, srcp_s1, crcp_s1;
	fx_t cpcy_s1, cpsy_s1, srsy_s1, srcy_s1, cy_s1, sy_s1, sp_s1;
	fx_t srspcy_s2, srspsy_s2, crspcy_s2, crspsy_s2;
	fx_t crsy_s2, crcy_s2, srcp_s2, crcp_s2, cpcy_s2, cpsy_s2, srsy_s2, srcy_s2, sp_s2;
	basis_t basis_s3;

	always_comb begin
		en[NST-1] = !valid_q[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			srsp_s1 <= fx_mul(in_trig.sr, in_trig.sp);
			crsp_s1 <= fx_mul(in_trig.cr, in_trig.sp);
			crsy_s1 <= fx_mul(in_trig.cr, in_trig.sy);
			crcy_s1 <= fx_mul(in_trig.cr, in_trig.cy);
			srcp_s1 <= fx_mul(in_trig.sr, in_trig.cp);
			crcp_s1 <= fx_mul(in_trig.cr, in_trig.cp);
			cpcy_s1 <= fx_mul(in_trig.cp, in_trig.cy);
			cpsy_s1 <= fx_mul(in_trig.cp, in_trig.sy);
			srsy_s1 <= fx_mul(in_trig.sr, in_trig.sy);
			srcy_s1 <= fx_mul(in_trig.cy, in_trig.sr);
			cy_s1   <= in_trig.cy;
			sy_s1   <= in_trig.sy;
			sp_s1   <= in_trig.sp;
		end
		if (en[1]) begin
			srspcy_s2 <= fx_mul(srsp_s1, cy_s1);
			srspsy_s2 <= fx_mul(srsp_s1, sy_s1);
			crspcy_s2 <= fx_mul(crsp_s1, cy_s1);
			crspsy_s2 <= fx_mul(crsp_s1, sy_s1);
			crsy_s2   <= crsy_s1;
			crcy_s2   <= crcy_s1;
			srcp_s2   <= srcp_s1;
			crcp_s2   <= crcp_s1;
			cpcy_s2   <= cpcy_s1;
			cpsy_s2   <= cpsy_s1;
			srsy_s2   <= srsy_s1;
			srcy_s2   <= srcy_s1;
			sp_s2     <= sp_s1;
		end
		if (en[2]) begin
			basis_s3.right_x <= sat(ext(crsy_s2) - ext(srspcy_s2));
			basis_s3.right_y <= sat(-(ext(srspsy_s2) + ext(crcy_s2)));
			basis_s3.right_z <= sat(ext(srcp_s2));
			basis_s3.up_x    <= sat(-(ext(crspcy_s2) + ext(srsy_s2)));
			basis_s3.up_y    <= sat(ext(srcy_s2) - ext(crspsy_s2));
			basis_s3.up_z    <= sat(ext(crcp_s2));
			basis_s3.fwd_x   <= sat(ext(cpcy_s2) + ext(cpcy_s2));
			basis_s3.fwd_y   <= sat(ext(cpsy_s2) + ext(cpsy_s2));
			basis_s3.fwd_z   <= sat(ext(sp_s2) + ext(sp_s2));
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[NST-1];
	assign out_basis = basis_s3;

endmodule

@@ dv/ecb_checker.sv @@
// Checker of the camera basis block: watches both stream channels, predicts the
// nine basis values for every angle triple taken in and compares each result.
// Depends on ecb_pkg for widths and the result layout.
module ecb_checker
	import ecb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     fail_count,
	output int                     pending
);

	localparam longint SIN_C1  = 1686629713;
	localparam longint SIN_C3  = 693598668;
	localparam longint SIN_C5  = 85569306;
	localparam longint SIN_C7  = 5026995;
	localparam longint SIN_C9  = 172271;
	localparam longint SIN_C11 = 3864;
	localparam longint UNIT    = longint'(1) <<< FRAC_BITS;
	localparam longint SPAN    = longint'(1) <<< (FRAC_BITS + 1);

	logic [OUT_W-1:0] basis_due [$];
	int               mismatches;
	string            field_names [9] = '{"right_x", "right_y", "right_z", "up_x", "up_y",
	                                      "up_z", "fwd_x", "fwd_y", "fwd_z"};

	initial begin
		mismatches = 0;
		fail_count = 0;
		pending    = 0;
	end

	// sin(pi/2 * u / quarter turn), odd polynomial in Q30, rounded to FRAC_BITS
	function automatic longint quarter_wave_sine(longint u);
		longint t, t2, p, r;
		t  = u <<< (30 - QBITS);
		t2 = (t * t) >>> 30;
		p  = SIN_C11;
		p  = SIN_C9 - ((p * t2) >>> 30);
		p  = SIN_C7 - ((p * t2) >>> 30);
		p  = SIN_C5 - ((p * t2) >>> 30);
		p  = SIN_C3 - ((p * t2) >>> 30);
		p  = SIN_C1 - ((p * t2) >>> 30);
		r  = (p * t) >>> 30;
		if (r < 0) begin
			r = 0;
		end
		r = (r + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (r > UNIT) begin
			r = UNIT;
		end
		return r;
	endfunction

	function automatic longint binary_angle_sine(angle_t a);
		logic [1:0] quad;
		longint     frac;
		longint     v;
		quad = a[ANGLE_BITS-1 -: 2];
		frac = longint'(a[QBITS-1:0]);
		if (quad[0]) begin
			frac = (longint'(1) <<< QBITS) - frac;
		end
		v = quarter_wave_sine(frac);
		return quad[1] ? -v : v;
	endfunction

	function automatic longint binary_angle_cosine(angle_t a);
		return binary_angle_sine(angle_t'(a + (1 << QBITS)));
	endfunction

	function automatic longint rounded_product(longint a, longint b);
		longint p, m;
		p = a * b;
		m = (p < 0) ? -p : p;
		m = (m + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return (p < 0) ? -m : m;
	endfunction

	function automatic out_t clamp_to_q2(longint v);
		if (v > SPAN) begin
			v = SPAN;
		end else if (v < -SPAN) begin
			v = -SPAN;
		end
		return out_t'(v);
	endfunction

	function automatic logic [OUT_W-1:0] camera_basis_of(logic [IN_TDATA_W-1:0] d);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		basis_t b;
		sp   = binary_angle_sine(d[0 +: ANGLE_BITS]);
		cp   = binary_angle_cosine(d[0 +: ANGLE_BITS]);
		sy   = binary_angle_sine(d[ANGLE_BITS +: ANGLE_BITS]);
		cy   = binary_angle_cosine(d[ANGLE_BITS +: ANGLE_BITS]);
		sr   = binary_angle_sine(d[2*ANGLE_BITS +: ANGLE_BITS]);
		cr   = binary_angle_cosine(d[2*ANGLE_BITS +: ANGLE_BITS]);
		srsp = rounded_product(sr, sp);
		crsp = rounded_product(cr, sp);
		b.right_x = clamp_to_q2(rounded_product(cr, sy) - rounded_product(srsp, cy));
		b.right_y = clamp_to_q2(-(rounded_product(srsp, sy) + rounded_product(cr, cy)));
		b.right_z = clamp_to_q2(rounded_product(sr, cp));
		b.up_x    = clamp_to_q2(-(rounded_product(crsp, cy) + rounded_product(sr, sy)));
		b.up_y    = clamp_to_q2(rounded_product(cy, sr) - rounded_product(crsp, sy));
		b.up_z    = clamp_to_q2(rounded_product(cr, cp));
		b.fwd_x   = clamp_to_q2(2 * rounded_product(cp, cy));
		b.fwd_y   = clamp_to_q2(2 * rounded_product(cp, sy));
		b.fwd_z   = clamp_to_q2(2 * sp);
		return b;
	endfunction

	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		out_t             e, a;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (basis_due.size() == 0) begin
					$error("result transfer with no angle triple outstanding");
					mismatches++;
				end else begin
					want = basis_due.pop_front();
					for (int i = 0; i < 9; i++) begin
						e = want[i*OW +: OW];
						a = m_axis_tdata[i*OW +: OW];
						if (a !== e) begin
							$error("%s expected %0d actual %0d", field_names[i], e, a);
							mismatches++;
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				basis_due.push_back(camera_basis_of(s_axis_tdata));
			end
		end
		fail_count <= mismatches;
		pending    <= basis_due.size();
	end

endmodule

@@ dv/testbench.sv @@
// Top of the camera basis test: clock, reset, angle stimulus and result back-pressure.
// Depends on ecb_pkg, euler_to_camera_basis and ecb_checker, which checks every result.
module testbench;
	import ecb_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 400000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	int                     fail_count;
	int                     pending;
	int                     cycle_count;
	bit                     calm;

	euler_to_camera_basis dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ecb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// hold the triple until the transfer happens
	task automatic push_angles(input angle_t pitch, input angle_t yaw, input angle_t roll);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {roll, yaw, pitch};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic angle_t pick_angle();
		if ($urandom_range(0, 3) == 0) begin
			return angle_t'($urandom_range(0, 3) * (1 << QBITS) + $urandom_range(0, 6) - 3);
		end
		return angle_t'($urandom);
	endfunction

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 25)) @(posedge clk);
				if (!calm) begin
					m_axis_tready <= 1'b0;
					repeat ($urandom_range(1, 18)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		angle_t q;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		calm          = 1'b0;
		q             = angle_t'(1 << QBITS);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_angles(16'h0000, 16'h0000, 16'h0000);
		push_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_angles(q, 16'h0000, 16'h0000);
		push_angles(angle_t'(3 * q), 16'h0000, 16'h0000);
		push_angles(angle_t'(2 * q), angle_t'(2 * q), angle_t'(2 * q));
		push_angles(16'h0000, q, 16'h0000);
		push_angles(16'h0000, angle_t'(3 * q), 16'h0000);
		push_angles(16'h0000, 16'h0000, q);
		push_angles(16'h0000, 16'h0000, angle_t'(3 * q));
		push_angles(angle_t'(q - 1), angle_t'(q + 1), angle_t'(q - 1));
		push_angles(angle_t'(2 * q - 1), angle_t'(2 * q + 1), angle_t'(3 * q + 1));
		push_angles(16'h0001, 16'h0001, 16'h0001);
		push_angles(16'h2000, 16'h2000, 16'h2000);
		push_angles(16'h6000, 16'hA000, 16'hE000);
		push_angles(16'h5555, 16'hAAAA, 16'h5555);
		push_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		push_angles(q, q, q);
		push_angles(angle_t'(3 * q), angle_t'(3 * q), angle_t'(3 * q));
		push_angles(16'h8000, 16'h7FFF, 16'h8001);
		push_angles(16'h3FFF, 16'hC000, 16'hBFFF);
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300) begin
				calm = 1'b1;
			end
			if (i == 450) begin
				calm = 1'b0;
			end
			if (i == RANDOM_ITEMS - 150) begin
				calm = 1'b1;
			end
			if (i % 200 == 100 && !calm) begin
				drain_results();
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			push_angles(pick_angle(), pick_angle(), pick_angle());
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/ecb_pkg.sv
src/ecb_sine.sv
src/ecb_trig.sv
src/ecb_basis.sv
src/euler_to_camera_basis.sv
dv/ecb_checker.sv
dv/testbench.sv
